FILE: rtl/pfe_pkg.sv
// Shared types and constants for the postfix stack evaluator.
`timescale 1ns / 1ps

package pfe_pkg;

    localparam int TOKEN_W     = 8;
    localparam int VALUE_W     = 32;
    localparam int STATUS_W    = 2;
    localparam int IMM_W       = 9;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [TOKEN_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [TOKEN_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [TOKEN_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [TOKEN_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [TOKEN_W-1:0] CH_SLASH = 8'h2F;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DIVZ  = 2'd3;

    typedef enum logic [2:0] {
        OP_PUSH,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } op_t;

    typedef struct packed {
        op_t                     op;
        logic signed [IMM_W-1:0] imm;
        logic                    last;
    } pfe_cmd_t;

    typedef struct packed {
        logic done;
        logic div_zero;
    } pfe_md_status_t;

    // Turns one character into a command for the back end.
    function automatic pfe_cmd_t classify(input logic [TOKEN_W-1:0] ch, input logic last);
        pfe_cmd_t c;
        c.last = last;
        c.imm  = $signed({1'b0, ch}) - $signed({1'b0, CH_ZERO});
        case (ch)
            CH_PLUS:  c.op = OP_ADD;
            CH_MINUS: c.op = OP_SUB;
            CH_STAR:  c.op = OP_MUL;
            CH_SLASH: c.op = OP_DIV;
            default:  c.op = OP_PUSH;
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/pfe_if.sv
// Handshake channel interfaces for the token input and the result output.
`timescale 1ns / 1ps

interface pfe_token_if import pfe_pkg::*;;
    logic               valid;
    logic               ready;
    logic [TOKEN_W-1:0] token;
    logic               end_of_expr;

    modport source (output valid, output token, output end_of_expr, input ready);
    modport sink   (input valid, input token, input end_of_expr, output ready);
endinterface

interface pfe_result_if import pfe_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic [STATUS_W-1:0]       status;

    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

FILE: rtl/postfix_stack_evaluator_top.sv
// A multiply or divide runs on the shared shift-add/restoring unit. The back end takes a
// new command only when it is through with the last one; its pace is set by the back-end
// sequencer and the single read port of the stack RAM.
// Reset is asynchronous and empties the stack and status at once; stack RAM contents
// are never cleared, since entries above the stack count are never read.
`timescale 1ns / 1ps

module postfix_stack_evaluator_top import pfe_pkg::*; #(
    parameter int STACK_DEPTH = 64,
    parameter int DATA_WIDTH  = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    pfe_token_if.sink    token_ch,
    pfe_result_if.source result_ch
);

    logic     q_push_valid;
    logic     q_push_ready;
    pfe_cmd_t q_push_data;
    logic     cmd_valid;
    pfe_cmd_t cmd;
    logic     cmd_pop;

    pfe_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .token_ch (token_ch),
        .q_valid  (q_push_valid),
        .q_data   (q_push_data),
        .q_ready  (q_push_ready)
    );

    pfe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data),
        .pop_valid  (cmd_valid),
        .pop_data   (cmd),
        .pop        (cmd_pop)
    );

    pfe_back #(
        .STACK_DEPTH (STACK_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .result_ch (result_ch)
    );

    // The back end only takes a command that the queue holds.
    assert property (@(posedge clk) disable iff (!rst_n) cmd_pop |-> cmd_valid)
        else $error("back end popped an empty command queue");

    // An accepted token shows up at the queue input in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        token_ch.valid && token_ch.ready |=> q_push_valid)
        else $error("accepted token was not forwarded by the front end");

    // A command the queue refused stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push_valid && !q_push_ready |=> q_push_valid && $stable(q_push_data))
        else $error("front end dropped a command the queue refused");

endmodule

FILE: rtl/pfe_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module pfe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/pfe_muldiv.sv
// Shared iterative unit: shift-add multiply and restoring signed divide.
`timescale 1ns / 1ps

module pfe_muldiv import pfe_pkg::*; #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  is_div,
    input  logic [DATA_WIDTH-1:0] op_a,
    input  logic [DATA_WIDTH-1:0] op_b,
    output logic [DATA_WIDTH-1:0] result,
    output pfe_md_status_t        status
);

    localparam int CW = $clog2(DATA_WIDTH + 1);

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_RUN,
        MD_DONE
    } md_state_t;

    md_state_t             state_reg;
    logic [CW-1:0]         cnt_reg;
    logic [DATA_WIDTH:0]   acc_reg;
    logic [DATA_WIDTH-1:0] x_reg;
    logic [DATA_WIDTH-1:0] y_reg;
    logic                  div_reg;
    logic                  neg_reg;
    logic                  done_reg;
    logic                  divz_reg;
    logic [DATA_WIDTH-1:0] result_reg;

    logic [DATA_WIDTH:0]   rem_shift;
    logic [DATA_WIDTH:0]   rem_diff;
    logic                  fits;
    logic [DATA_WIDTH-1:0] mag_a;
    logic [DATA_WIDTH-1:0] mag_b;
    logic [DATA_WIDTH-1:0] mul_sum;

    always_comb
    begin
        rem_shift = {acc_reg[DATA_WIDTH-1:0], x_reg[DATA_WIDTH-1]};
        rem_diff  = rem_shift - {1'b0, y_reg};
        fits      = !rem_diff[DATA_WIDTH];
        mag_a     = op_a[DATA_WIDTH-1] ? (~op_a + 1'b1) : op_a;
        mag_b     = op_b[DATA_WIDTH-1] ? (~op_b + 1'b1) : op_b;
        mul_sum   = acc_reg[DATA_WIDTH-1:0] + x_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= MD_IDLE;
            cnt_reg    <= '0;
            acc_reg    <= '0;
            x_reg      <= '0;
            y_reg      <= '0;
            div_reg    <= 1'b0;
            neg_reg    <= 1'b0;
            done_reg   <= 1'b0;
            divz_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            // Done pulses after a divide by zero is caught, or after the last step.
            done_reg <= ((state_reg == MD_IDLE) && start && is_div && (op_b == '0))
                        || (state_reg == MD_DONE);
            case (state_reg)
                MD_IDLE:
                begin
                    if (start)
                    begin
                        div_reg <= is_div;
                        acc_reg <= '0;
                        cnt_reg <= CW'(DATA_WIDTH);
                        if (is_div && (op_b == '0))
                        begin
                            result_reg <= '0;
                            divz_reg   <= 1'b1;
                        end
                        else if (is_div)
                        begin
                            x_reg     <= mag_a;
                            y_reg     <= mag_b;
                            neg_reg   <= op_a[DATA_WIDTH-1] ^ op_b[DATA_WIDTH-1];
                            state_reg <= MD_RUN;
                        end
                        else
                        begin
                            x_reg     <= op_a;
                            y_reg     <= op_b;
                            state_reg <= MD_RUN;
                        end
                    end
                end
                MD_RUN:
                begin
                    if (div_reg)
                    begin
                        // Quotient bits shift in where dividend bits leave.
                        acc_reg <= fits ? rem_diff : rem_shift;
                        x_reg   <= {x_reg[DATA_WIDTH-2:0], fits};
                    end
                    else
                    begin
                        if (y_reg[0])
                        begin
                            acc_reg <= {1'b0, mul_sum};
                        end
                        x_reg <= {x_reg[DATA_WIDTH-2:0], 1'b0};
                        y_reg <= {1'b0, y_reg[DATA_WIDTH-1:1]};
                    end
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CW'(1))
                    begin
                        state_reg <= MD_DONE;
                    end
                end
                MD_DONE:
                begin
                    if (div_reg)
                    begin
                        result_reg <= neg_reg ? (~x_reg + 1'b1) : x_reg;
                    end
                    else
                    begin
                        result_reg <= acc_reg[DATA_WIDTH-1:0];
                    end
                    divz_reg  <= 1'b0;
                    state_reg <= MD_IDLE;
                end
                default:
                begin
                    state_reg <= MD_IDLE;
                end
            endcase
        end
    end

    assign result          = result_reg;
    assign status.done     = done_reg;
    assign status.div_zero = divz_reg;

endmodule

FILE: rtl/pfe_front.sv
// Front end: takes tokens, classifies them and hands commands to the queue.
`timescale 1ns / 1ps

module pfe_front import pfe_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    pfe_token_if.sink         token_ch,
    output logic              q_valid,
    output pfe_cmd_t          q_data,
    input  logic              q_ready
);

    logic     hold_valid_reg;
    pfe_cmd_t hold_reg;

    assign token_ch.ready = !hold_valid_reg || q_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            if (token_ch.valid && token_ch.ready)
            begin
                hold_valid_reg <= 1'b1;
            end
            else if (q_ready)
            begin
                hold_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (token_ch.valid && token_ch.ready)
        begin
            hold_reg <= classify(token_ch.token, token_ch.end_of_expr);
        end
    end

    assign q_valid = hold_valid_reg;
    assign q_data  = hold_reg;

endmodule

FILE: rtl/pfe_queue.sv
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps

module pfe_queue import pfe_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push_valid,
    output logic     push_ready,
    input  pfe_cmd_t push_data,
    output logic     pop_valid,
    output pfe_cmd_t pop_data,
    input  logic     pop
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    pfe_cmd_t      slot_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [NW-1:0] fill_reg;
    logic          do_push;
    logic          do_pop;

    assign push_ready = (fill_reg != NW'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/pfe_back.sv
// Back end: runs commands against the operand stack and issues results.
`timescale 1ns / 1ps

module pfe_back import pfe_pkg::*; #(
    parameter int STACK_DEPTH = 64,
    parameter int DATA_WIDTH  = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cmd_valid,
    input  pfe_cmd_t     cmd,
    output logic         cmd_pop,
    pfe_result_if.source result_ch
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [2:0] {
        B_IDLE,
        B_OPND,
        B_EXEC,
        B_MDWAIT,
        B_FINISH
    } back_state_t;

    back_state_t               state_reg;
    logic [CW-1:0]             count_reg;
    logic [DATA_WIDTH-1:0]     top_reg;
    logic [STATUS_W-1:0]       sticky_reg;
    pfe_cmd_t                  cmd_reg;
    logic [DATA_WIDTH-1:0]     opa_reg;
    logic [DATA_WIDTH-1:0]     opb_reg;
    logic [AW-1:0]             base_reg;
    logic                      out_valid_reg;
    logic signed [VALUE_W-1:0] out_value_reg;
    logic [STATUS_W-1:0]       out_status_reg;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    logic                  md_start;
    logic [DATA_WIDTH-1:0] md_result;
    pfe_md_status_t        md_status;

    logic [CW-1:0]         count_m2;
    logic                  stack_full;
    logic                  two_operands;
    logic [DATA_WIDTH-1:0] imm_ext;
    logic [DATA_WIDTH-1:0] alu_res;
    logic                  cmd_is_addsub;
    logic                  out_load;

    assign count_m2      = count_reg - CW'(2);
    assign stack_full    = (count_reg == CW'(STACK_DEPTH));
    assign two_operands  = (count_reg >= CW'(2));
    assign imm_ext       = DATA_WIDTH'(cmd.imm);
    assign alu_res       = (cmd_reg.op == OP_SUB) ? (opa_reg - opb_reg) : (opa_reg + opb_reg);
    assign cmd_is_addsub = (cmd_reg.op == OP_ADD) || (cmd_reg.op == OP_SUB);
    assign out_load      = (state_reg == B_FINISH) && cmd_reg.last
                           && (!out_valid_reg || result_ch.ready);

    pfe_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pfe_muldiv #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (md_start),
        .is_div (cmd_reg.op == OP_DIV),
        .op_a   (opa_reg),
        .op_b   (opb_reg),
        .result (md_result),
        .status (md_status)
    );

    always_comb
    begin
        cmd_pop   = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = count_reg[AW-1:0];
        ram_wdata = imm_ext;
        ram_raddr = count_m2[AW-1:0];
        md_start  = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                cmd_pop = cmd_valid;
                if (cmd_valid && (cmd.op == OP_PUSH) && !stack_full)
                begin
                    ram_we = 1'b1;
                end
            end
            B_EXEC:
            begin
                if (cmd_is_addsub)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = base_reg;
                    ram_wdata = alu_res;
                end
                else
                begin
                    md_start = 1'b1;
                end
            end
            B_MDWAIT:
            begin
                if (md_status.done)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = base_reg;
                    ram_wdata = md_result;
                end
            end
            default:
            begin
                cmd_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            count_reg      <= '0;
            top_reg        <= '0;
            sticky_reg     <= ST_OK;
            cmd_reg        <= '0;
            opa_reg        <= '0;
            opb_reg        <= '0;
            base_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_value_reg  <= '0;
            out_status_reg <= ST_OK;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        cmd_reg <= cmd;
                        if (cmd.op == OP_PUSH)
                        begin
                            if (stack_full)
                            begin
                                if (sticky_reg == ST_OK)
                                begin
                                    sticky_reg <= ST_OVER;
                                end
                            end
                            else
                            begin
                                top_reg   <= imm_ext;
                                count_reg <= count_reg + 1'b1;
                            end
                            state_reg <= B_FINISH;
                        end
                        else
                        begin
                            // Missing operands read as zero; the result lands at the bottom.
                            opb_reg  <= (count_reg != '0) ? top_reg : '0;
                            base_reg <= two_operands ? count_m2[AW-1:0] : '0;
                            if (two_operands)
                            begin
                                state_reg <= B_OPND;
                            end
                            else
                            begin
                                opa_reg <= '0;
                                if (sticky_reg == ST_OK)
                                begin
                                    sticky_reg <= ST_UNDER;
                                end
                                state_reg <= B_EXEC;
                            end
                        end
                    end
                end
                B_OPND:
                begin
                    opa_reg   <= ram_rdata;
                    state_reg <= B_EXEC;
                end
                B_EXEC:
                begin
                    if (cmd_is_addsub)
                    begin
                        top_reg   <= alu_res;
                        count_reg <= CW'(base_reg) + 1'b1;
                        state_reg <= B_FINISH;
                    end
                    else
                    begin
                        state_reg <= B_MDWAIT;
                    end
                end
                B_MDWAIT:
                begin
                    if (md_status.done)
                    begin
                        top_reg   <= md_result;
                        count_reg <= CW'(base_reg) + 1'b1;
                        if (md_status.div_zero && (sticky_reg == ST_OK))
                        begin
                            sticky_reg <= ST_DIVZ;
                        end
                        state_reg <= B_FINISH;
                    end
                end
                B_FINISH:
                begin
                    if (!cmd_reg.last)
                    begin
                        state_reg <= B_IDLE;
                    end
                    else if (!out_valid_reg || result_ch.ready)
                    begin
                        if (count_reg == '0)
                        begin
                            out_value_reg  <= '0;
                            out_status_reg <= (sticky_reg == ST_OK) ? ST_UNDER : sticky_reg;
                        end
                        else
                        begin
                            out_value_reg  <= VALUE_W'($signed(top_reg));
                            out_status_reg <= sticky_reg;
                        end
                        count_reg  <= '0;
                        sticky_reg <= ST_OK;
                        state_reg  <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    assign result_ch.valid  = out_valid_reg;
    assign result_ch.value  = out_value_reg;
    assign result_ch.status = out_status_reg;

endmodule
